>>> rtl/core/bdsd_pkg.sv
// ----------------------------------------------------------------------------
// bdsd_pkg
// Shared types and constants of the button debounce and stuck detect block.
// ----------------------------------------------------------------------------
package bdsd_pkg;

  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int PIN_COUNT  = 8;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_UP_DEBOUNCE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DOWN_DEBOUNCE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AUX_DEBOUNCE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UP_RESET_TO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DOWN_RESET_TO = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_UP_STUCK_TO   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DOWN_STUCK_TO = 3'd6;

  // reset values of the registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] RESET_TO_RST = 16'd100;
  localparam logic [CFG_W-1:0] STUCK_TO_RST = 16'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] up_debounce;
    logic [CFG_W-1:0] down_debounce;
    logic [CFG_W-1:0] aux_debounce;
    logic [CFG_W-1:0] up_reset_to;
    logic [CFG_W-1:0] down_reset_to;
    logic [CFG_W-1:0] up_stuck_to;
    logic [CFG_W-1:0] down_stuck_to;
  } cfg_t;

  // timing settings seen by one button
  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] reset_to;
    logic [CFG_W-1:0] stuck_to;
  } btn_cfg_t;

endpackage

>>> rtl/core/button_debounce_stuck_detect.sv
// ----------------------------------------------------------------------------
// button_debounce_stuck_detect
// Timestamp based debounce of eight buttons with stuck detection on the
// up and down shift buttons.
// ----------------------------------------------------------------------------
// Takes one sample (timestamp and active-low pins) per clock while out_ready
// stays high and returns one result per sample. A sample waits in the input
// register; the button state is updated as it moves into the result, so the
// held, pressed and stuck outputs are registered. The sustained rate is one
// sample per cycle while out_ready stays high, set by the single
// compare-and-add pass per button on registered state; out_ready low holds the
// result and stops input after one more sample. All times are unsigned ms
// values of TIME_WIDTH bits without wrap handling. Configuration registers may
// be written only while idle.
// ----------------------------------------------------------------------------
module button_debounce_stuck_detect import bdsd_pkg::*; #(
  parameter int NUM_BUTTONS = 8,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_now_ms,
  input  logic [7:0]            in_pin_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_held_mask,
  output logic [7:0]            out_pressed_mask,
  output logic [1:0]            out_stuck_errors
);

  cfg_t                  cfg;
  logic                  in_full_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [7:0]            pins_r;
  logic                  out_valid_r;
  logic                  advance;
  logic [NUM_BUTTONS-1:0] held_vec;
  logic [NUM_BUTTONS-1:0] pressed_vec;
  logic [NUM_BUTTONS-1:0] stuck_vec;

  // configuration registers
  bdsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a sample moves on when the result slot is free or being emptied
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= TIME_WIDTH'(in_now_ms);
      pins_r <= in_pin_levels;
    end
  end

  // result valid, the button state itself is the result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // one lane per button
  generate
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
      logic     pin;
      btn_cfg_t tcfg;

      if (b < PIN_COUNT) begin : g_pin
        assign pin = pins_r[b];
      end else begin : g_nopin
        assign pin = 1'b1;
      end

      if (b == 0) begin : g_up
        assign tcfg = '{debounce: cfg.up_debounce, reset_to: cfg.up_reset_to,
                        stuck_to: cfg.up_stuck_to};
      end else if (b == 1) begin : g_down
        assign tcfg = '{debounce: cfg.down_debounce, reset_to: cfg.down_reset_to,
                        stuck_to: cfg.down_stuck_to};
      end else begin : g_aux
        assign tcfg = '{debounce: cfg.aux_debounce, reset_to: '0, stuck_to: '0};
      end

      bdsd_button #(
        .TIME_WIDTH (TIME_WIDTH),
        .IS_SHIFT   (b < 2)
      ) u_btn (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .now       (now_r),
        .pin_level (pin),
        .tcfg      (tcfg),
        .held      (held_vec[b]),
        .pressed   (pressed_vec[b]),
        .stuck     (stuck_vec[b])
      );
    end

    // output mapping, missing buttons read as zero
    for (genvar i = 0; i < PIN_COUNT; i++) begin : g_out
      if (i < NUM_BUTTONS) begin : g_map
        assign out_held_mask[i]    = held_vec[i];
        assign out_pressed_mask[i] = pressed_vec[i];
      end else begin : g_zero
        assign out_held_mask[i]    = 1'b0;
        assign out_pressed_mask[i] = 1'b0;
      end
    end
  endgenerate

  assign out_stuck_errors = {stuck_vec[1], stuck_vec[0]};
  assign out_valid        = out_valid_r;

endmodule

>>> rtl/core/bdsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdsd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bdsd_cfg_regs import bdsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // address decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_UP_DEBOUNCE:   cfg_nxt.up_debounce   = cfg_wdata;
        REG_DOWN_DEBOUNCE: cfg_nxt.down_debounce = cfg_wdata;
        REG_AUX_DEBOUNCE:  cfg_nxt.aux_debounce  = cfg_wdata;
        REG_UP_RESET_TO:   cfg_nxt.up_reset_to   = cfg_wdata;
        REG_DOWN_RESET_TO: cfg_nxt.down_reset_to = cfg_wdata;
        REG_UP_STUCK_TO:   cfg_nxt.up_stuck_to   = cfg_wdata;
        REG_DOWN_STUCK_TO: cfg_nxt.down_stuck_to = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_debounce   <= DEBOUNCE_RST;
      cfg_r.down_debounce <= DEBOUNCE_RST;
      cfg_r.aux_debounce  <= DEBOUNCE_RST;
      cfg_r.up_reset_to   <= RESET_TO_RST;
      cfg_r.down_reset_to <= RESET_TO_RST;
      cfg_r.up_stuck_to   <= STUCK_TO_RST;
      cfg_r.down_stuck_to <= STUCK_TO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/bdsd_button.sv
// ----------------------------------------------------------------------------
// bdsd_button
// State and update logic of one button: lockout deadline, held and pressed
// latches, and for a shift button the release time and stuck error.
// ----------------------------------------------------------------------------
module bdsd_button import bdsd_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter bit IS_SHIFT   = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  update,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic                  pin_level,
  input  btn_cfg_t              tcfg,
  output logic                  held,
  output logic                  pressed,
  output logic                  stuck
);

  logic [TIME_WIDTH-1:0] deadline_r;
  logic [TIME_WIDTH-1:0] deadline_nxt;
  logic                  held_r;
  logic                  held_nxt;
  logic                  pressed_r;
  logic                  pressed_nxt;
  logic                  pressed_latch;
  logic                  active;
  logic                  press;
  logic                  release_evt;

  // press and release detection, pins are active low
  assign active      = ~pin_level;
  assign press       = active && (deadline_r < now) && !held_r;
  assign release_evt = !active && held_r;

  always_comb begin
    held_nxt      = held_r;
    pressed_latch = pressed_r;
    deadline_nxt  = deadline_r;
    if (press) begin
      held_nxt      = 1'b1;
      pressed_latch = 1'b1;
      deadline_nxt  = now + TIME_WIDTH'(tcfg.debounce);
    end else if (release_evt) begin
      held_nxt      = 1'b0;
      pressed_latch = 1'b0;
    end
  end

  generate
    if (IS_SHIFT) begin : g_shift
      logic [TIME_WIDTH-1:0] rel_time_r;
      logic [TIME_WIDTH-1:0] rel_time_nxt;
      logic                  stuck_r;
      logic                  stuck_nxt;
      logic [TIME_WIDTH-1:0] reset_at;
      logic [TIME_WIDTH-1:0] stuck_at;
      logic [TIME_WIDTH-1:0] unstuck_at;

      assign rel_time_nxt = release_evt ? now : rel_time_r;
      assign reset_at     = deadline_nxt + TIME_WIDTH'(tcfg.reset_to);
      assign stuck_at     = deadline_nxt + TIME_WIDTH'(tcfg.stuck_to);
      assign unstuck_at   = rel_time_nxt + TIME_WIDTH'(tcfg.stuck_to);

      // pressed clears itself once the reset timeout has run out
      assign pressed_nxt = pressed_latch && !(reset_at < now);

      // stuck sets while held too long, clears after as long released
      always_comb begin
        stuck_nxt = stuck_r;
        if (held_nxt) begin
          if (stuck_at < now) begin
            stuck_nxt = 1'b1;
          end
        end else if (unstuck_at < now) begin
          stuck_nxt = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rel_time_r <= '0;
          stuck_r    <= 1'b0;
        end else if (update) begin
          rel_time_r <= rel_time_nxt;
          stuck_r    <= stuck_nxt;
        end
      end

      assign stuck = stuck_r;
    end else begin : g_aux
      assign pressed_nxt = pressed_latch;
      assign stuck       = 1'b0;
    end
  endgenerate

  // button state, moves only on update, as a sample passes into the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
      held_r     <= 1'b0;
      pressed_r  <= 1'b0;
    end else if (update) begin
      deadline_r <= deadline_nxt;
      held_r     <= held_nxt;
      pressed_r  <= pressed_nxt;
    end
  end

  assign held    = held_r;
  assign pressed = pressed_r;

endmodule

>>> rtl/core/bdsd_checker.sv
// ----------------------------------------------------------------------------
// bdsd_checker
// Port level checks of the button debounce block, bound to the top level.
// ----------------------------------------------------------------------------
module bdsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_held_mask,
  input logic [7:0] out_pressed_mask,
  input logic [1:0] out_stuck_errors
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_held_mask)
      && $stable(out_pressed_mask) && $stable(out_stuck_errors))
    else $error("stalled result changed");

  // a pressed latch never stands without the held state
  a_pressed_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressed_mask & ~out_held_mask) == 8'd0)
    else $error("pressed without held");

  // a stuck error only rises while its button is held
  a_stuck_held: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_stuck_errors[0]) |-> out_held_mask[0])
      and ($rose(out_stuck_errors[1]) |-> out_held_mask[1]))
    else $error("stuck error rose on a released button");

  // an empty result slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind button_debounce_stuck_detect bdsd_checker u_bdsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_held_mask    (out_held_mask),
  .out_pressed_mask (out_pressed_mask),
  .out_stuck_errors (out_stuck_errors)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debounce and stuck detect block.
// ----------------------------------------------------------------------------
// A short table of directed samples comes first. Its rows hit the strict
// lockout compare, the shift auto-clear, stuck set and stuck clear, and
// timestamps at the top of the range with deadlines that wrap. Six phases of
// random samples follow under register settings of reset values, all zero,
// all ones, small values, full random values and reset values again. The
// pins in the random phases follow held/released runs with contact bounce
// glitches on top. Time mostly moves forward, with some backward steps and
// jumps. Every result is compared field by field against the typed result
// of a directed row where given, else an in-bench model of the button state.
// ----------------------------------------------------------------------------
module tb;
  import bdsd_pkg::*;

  localparam int N_DIR_ROWS      = 17;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int PRINT_LIMIT     = 40;

  // one result transaction
  typedef struct packed {
    logic [7:0] held;
    logic [7:0] pressed;
    logic [1:0] stuck;
  } debounce_result_t;

  // directed row: sample plus a typed result where one is given
  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  pins;
    logic        typed;
    logic [7:0]  held;
    logic [7:0]  pressed;
    logic [1:0]  stuck;
  } dir_row_t;

  localparam cfg_t CFG_DEFAULTS = '{DEBOUNCE_RST, DEBOUNCE_RST, DEBOUNCE_RST,
                                    RESET_TO_RST, RESET_TO_RST,
                                    STUCK_TO_RST, STUCK_TO_RST};

  localparam dir_row_t DIR_ROWS [N_DIR_ROWS] = '{
    // idle pins after reset
    '{32'd0,         8'hFF, 1'b1, 8'h00, 8'h00, 2'd0},
    // deadline equal to the timestamp blocks the press
    '{32'd0,         8'h00, 1'b1, 8'h00, 8'h00, 2'd0},
    '{32'd1,         8'h00, 1'b1, 8'hFF, 8'hFF, 2'd0},
    // shift pressed latches clear after deadline plus reset timeout
    '{32'd152,       8'h00, 1'b1, 8'hFF, 8'hFC, 2'd0},
    // held past deadline plus stuck timeout
    '{32'd2052,      8'h00, 1'b1, 8'hFF, 8'hFC, 2'd3},
    // release keeps stuck until release time plus stuck timeout passes
    '{32'd2053,      8'hFF, 1'b1, 8'h00, 8'h00, 2'd3},
    '{32'd4053,      8'hFF, 1'b1, 8'h00, 8'h00, 2'd3},
    '{32'd4054,      8'hFF, 1'b1, 8'h00, 8'h00, 2'd0},
    // deadlines that wrap past the top of the time range
    '{32'hFFFF_FFF0, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'hFFFF_FFFF, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'h0000_0030, 8'h00, 1'b0, 8'h00, 8'h00, 2'd0},
    // alternating pins, lockout still running on half of them
    '{32'h0000_0030, 8'hAA, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'h0000_0031, 8'h55, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'h0000_0063, 8'h55, 1'b0, 8'h00, 8'h00, 2'd0},
    // time stepping backwards, then a far jump
    '{32'h0000_0010, 8'hFF, 1'b0, 8'h00, 8'h00, 2'd0},
    '{32'h8000_0000, 8'h7F, 1'b0, 8'h00, 8'h00, 2'd0}
  };

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr         = '0;
  logic [CFG_W-1:0]      cfg_wdata        = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic [31:0]           in_now_ms        = '0;
  logic [7:0]            in_pin_levels    = 8'hFF;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [7:0]            out_held_mask;
  logic [7:0]            out_pressed_mask;
  logic [1:0]            out_stuck_errors;

  // model of the button state
  cfg_t        settings_now  = CFG_DEFAULTS;
  logic [31:0] lockout_until [PIN_COUNT];
  logic [31:0] released_at   [2];
  logic [7:0]  held_now      = '0;
  logic [7:0]  pressed_now   = '0;
  logic [1:0]  stuck_now     = '0;

  debounce_result_t expected_results [$];
  bit               no_idle        = 1'b0;
  int               errors         = 0;
  int               results_seen   = 0;
  int               stuck_results  = 0;
  int               samples_sent   = 0;

  button_debounce_stuck_detect u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_ms        (in_now_ms),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_held_mask    (out_held_mask),
    .out_pressed_mask (out_pressed_mask),
    .out_stuck_errors (out_stuck_errors)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int b = 0; b < PIN_COUNT; b++) lockout_until[b] = '0;
    released_at[0] = '0;
    released_at[1] = '0;
  end

  // one sample through the debounce and stuck logic, updates the model
  function automatic debounce_result_t debounce_step(input logic [31:0] now,
                                                     input logic [7:0]  pins);
    logic [CFG_W-1:0] hold_off;
    logic [CFG_W-1:0] clear_after;
    logic [CFG_W-1:0] stuck_after;
    logic [31:0]      limit;
    for (int b = 0; b < PIN_COUNT; b++) begin
      hold_off = (b == 0) ? settings_now.up_debounce :
                 (b == 1) ? settings_now.down_debounce : settings_now.aux_debounce;
      // pins are active low; a press needs the lockout to have run out
      if (!pins[b] && lockout_until[b] < now && !held_now[b]) begin
        held_now[b]      = 1'b1;
        pressed_now[b]   = 1'b1;
        lockout_until[b] = now + 32'(hold_off);
      end else if (pins[b] && held_now[b]) begin
        held_now[b]    = 1'b0;
        pressed_now[b] = 1'b0;
        if (b < 2) released_at[b] = now;
      end
      // shift buttons: pressed auto-clear and stuck flag
      if (b < 2) begin
        clear_after = (b == 0) ? settings_now.up_reset_to : settings_now.down_reset_to;
        stuck_after = (b == 0) ? settings_now.up_stuck_to : settings_now.down_stuck_to;
        limit = lockout_until[b] + 32'(clear_after);
        if (pressed_now[b] && limit < now) pressed_now[b] = 1'b0;
        if (held_now[b]) begin
          limit = lockout_until[b] + 32'(stuck_after);
          if (limit < now) stuck_now[b] = 1'b1;
        end else begin
          limit = released_at[b] + 32'(stuck_after);
          if (limit < now) stuck_now[b] = 1'b0;
        end
      end
    end
    return '{held_now, pressed_now, stuck_now};
  endfunction

  // offer one sample, idling at random first; returns at a falling edge
  task automatic send_sample(input logic [31:0] now, input logic [7:0] pins,
                             input logic use_typed, input debounce_result_t typed);
    debounce_result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_now_ms     <= now;
    in_pin_levels <= pins;
    do @(posedge clk); while (!in_ready);
    predicted = debounce_step(now, pins);
    expected_results.push_back(use_typed ? typed : predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  // hold off input until every result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all registers plus the unmapped index, which must be ignored
  task automatic load_settings(input cfg_t s);
    logic [CFG_W-1:0] val;
    for (int i = 0; i < (1 << CFG_ADDR_W); i++) begin
      case (CFG_ADDR_W'(i))
        REG_UP_DEBOUNCE:   val = s.up_debounce;
        REG_DOWN_DEBOUNCE: val = s.down_debounce;
        REG_AUX_DEBOUNCE:  val = s.aux_debounce;
        REG_UP_RESET_TO:   val = s.up_reset_to;
        REG_DOWN_RESET_TO: val = s.down_reset_to;
        REG_UP_STUCK_TO:   val = s.up_stuck_to;
        REG_DOWN_STUCK_TO: val = s.down_stuck_to;
        default:           val = CFG_W'($urandom());
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= val;
      @(negedge clk);
    end
    cfg_we       <= 1'b0;
    settings_now  = s;
  endtask

  // result side stalls
  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    debounce_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_stuck_errors != 2'd0) stuck_results++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: result with nothing expected, expected none got %h %h %h",
                   $time, out_held_mask, out_pressed_mask, out_stuck_errors);
      end else begin
        want = expected_results.pop_front();
        check_field("held_mask", want.held, out_held_mask);
        check_field("pressed_mask", want.pressed, out_pressed_mask);
        check_field("stuck_errors", 8'(want.stuck), 8'(out_stuck_errors));
      end
    end
  end

  // stimulus
  initial begin
    cfg_t        s;
    int          roll;
    int          span;
    logic [31:0] stamp;
    logic [7:0]  pins_now;
    logic [7:0]  sample_pins;

    pins_now = 8'hFF;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under reset settings
    for (int r = 0; r < N_DIR_ROWS; r++)
      send_sample(DIR_ROWS[r].now, DIR_ROWS[r].pins, DIR_ROWS[r].typed,
                  '{DIR_ROWS[r].held, DIR_ROWS[r].pressed, DIR_ROWS[r].stuck});
    drain_results();

    // random phases, one register setting each
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: s = CFG_DEFAULTS;
        1: s = '0;
        2: s = '1;
        3: s = '{CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)),
                 CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 255)),
                 CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 1023)),
                 CFG_W'($urandom_range(0, 1023))};
        4: s = '{CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                 CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                 CFG_W'($urandom())};
        default: s = CFG_DEFAULTS;
      endcase
      if (phase != 0) load_settings(s);
      // long stretch with no idling on either side
      no_idle = (phase == 2);
      // step size scaled so holds reach the stuck and clear timeouts
      span  = (int'(s.up_stuck_to) + int'(s.down_stuck_to) + int'(s.aux_debounce)) / 24 + 3;
      stamp = (phase == 2) ? 32'hFFFE_0000 : 32'($urandom_range(0, 32'h000F_FFFF));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 3 && k == ITEMS_PER_PHASE / 2) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 3)      stamp = $urandom();
        else if (roll < 6) stamp = stamp - 32'($urandom_range(0, span));
        else               stamp = stamp + 32'($urandom_range(0, span));
        // shift buttons hold longer than the aux buttons
        for (int b = 0; b < PIN_COUNT; b++)
          if ($urandom_range(0, (b < 2) ? 39 : 11) == 0) pins_now[b] = !pins_now[b];
        sample_pins = pins_now;
        // contact bounce on a single pin
        if ($urandom_range(0, 9) == 0)
          sample_pins[$urandom_range(0, PIN_COUNT - 1)] ^= 1'b1;
        send_sample(stamp, sample_pins, 1'b0, '0);
      end
      drain_results();
    end

    no_idle = 1'b0;
    $display("ran %0d samples over %0d register settings plus a directed table",
             samples_sent, N_PHASES);
    $display("checked %0d results, %0d of them with a stuck flag raised",
             results_seen, stuck_results);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("button_debounce_stuck_detect: match");
    end else begin
      $display("button_debounce_stuck_detect: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("button_debounce_stuck_detect: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bdsd_pkg.sv
rtl/core/bdsd_cfg_regs.sv
rtl/core/bdsd_button.sv
rtl/core/button_debounce_stuck_detect.sv
rtl/core/bdsd_checker.sv
bench/tb.sv
